// ----- rtl/core/ecsc_pkg.sv -----
// Shared types, register codes and reset values for the encoder click setpoint control.
package ecsc_pkg;

  // Default detent divisor of the quadrature counter
  localparam int unsigned PulsesPerDetentDefault = 4;

  // Configuration port geometry: seven 32-bit registers at 4-byte spacing
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  // Register indexes
  typedef enum logic [2:0] {
    RegDefaultSetpoint = 3'd0,
    RegStepSize        = 3'd1,
    RegMinLimit        = 3'd2,
    RegMaxLimit        = 3'd3,
    RegInitialCount    = 3'd4,
    RegDebounceMs      = 3'd5,
    RegDoubleClickMs   = 3'd6
  } reg_idx_e;

  // Reset values
  localparam logic signed [15:0] DefaultSetpointReset = 16'sd0;
  localparam logic [14:0]        StepSizeReset        = 15'd50;
  localparam logic signed [15:0] MinLimitReset        = 16'sd0;
  localparam logic signed [15:0] MaxLimitReset        = 16'sd10000;
  localparam logic [15:0]        InitialCountReset    = 16'd0;
  localparam logic [15:0]        DebounceMsReset      = 16'd50;
  localparam logic [15:0]        DoubleClickMsReset   = 16'd400;

  // One poll
  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_pressed;
    logic [15:0] encoder_count;
  } in_item_t;

  // One result
  typedef struct packed {
    logic signed [15:0] setpoint;
    logic               edit_mode;
    logic               heating_enabled;
  } out_item_t;

  // Configuration register contents
  typedef struct packed {
    logic signed [15:0] default_setpoint;
    logic [14:0]        step_size;
    logic signed [15:0] min_limit;
    logic signed [15:0] max_limit;
    logic [15:0]        initial_count;
    logic [15:0]        debounce_ms;
    logic [15:0]        double_click_ms;
  } cfg_t;

  // State loads caused by register writes
  typedef struct packed {
    logic        setpoint_load;
    logic        count_load;
    logic [15:0] value;
  } cfg_load_t;

  // Item between the button/knob stage and the setpoint stage
  typedef struct packed {
    logic signed [15:0] steps;
    logic               edit_mode;
    logic               heating_enabled;
  } knob_item_t;

endpackage

// ----- rtl/core/encoder_click_setpoint_control.sv -----
// Top level: encoder and double-click driven heater setpoint control.
//
//   channel   direction  handshake            payload
//   in        input      in_valid_i/in_stall_o  in_data_i  (now_ms, button, counter)
//   out       output     out_valid_o/out_stall_i out_data_o (setpoint, edit, heating)
//   config    input      psel/penable/pwrite   paddr, pwdata, prdata
//
// One item per cycle while out_stall_i is low; an accepted item passes the input register, the
// debounce/click/detent register and the setpoint multiply/clamp register to out_valid_o.
// The setpoint multiply-add-clamp is the longest path.
// Reset empties the pipeline and loads the register reset values into the configuration, setpoint and count state.
// An output stall holds the result register; stages behind it fill, then in_stall_o rises.
module encoder_click_setpoint_control #(
  parameter int unsigned PulsesPerDetent = ecsc_pkg::PulsesPerDetentDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ecsc_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ecsc_pkg::out_item_t              out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ecsc_pkg::AddrWidth-1:0]   paddr,
  input  logic [ecsc_pkg::DataWidth-1:0]   pwdata,
  output logic [ecsc_pkg::DataWidth-1:0]   prdata,
  output logic                             pready
);

  ecsc_pkg::cfg_t         cfg;
  ecsc_pkg::cfg_load_t    load;
  ecsc_pkg::in_item_t     s0_q;
  ecsc_pkg::knob_item_t   s1_q, knob;
  ecsc_pkg::out_item_t    s2_q, result;
  logic                   s0_valid_q, s1_valid_q, s2_valid_q;
  logic                   adv0, adv1, adv2, move01, move12;

  assign pready = 1'b1;

  ecsc_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg),
    .load_o    (load)
  );

  // Pipeline flow: a stage moves when the one after it is empty or moving
  assign adv2       = !s2_valid_q || !out_stall_i;
  assign move12     = s1_valid_q && adv2;
  assign adv1       = !s1_valid_q || adv2;
  assign move01     = s0_valid_q && adv1;
  assign adv0       = !s0_valid_q || adv1;
  assign in_stall_o = !adv0;

  ecsc_input #(
    .PulsesPerDetent (PulsesPerDetent)
  ) u_input (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (move01),
    .item_i (s0_q),
    .cfg_i  (cfg),
    .load_i (load),
    .knob_o (knob)
  );

  ecsc_setpoint u_setpoint (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (move12),
    .knob_i   (s1_q),
    .cfg_i    (cfg),
    .load_i   (load),
    .result_o (result)
  );

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv0) begin
        s0_valid_q <= in_valid_i;
      end
      if (adv1) begin
        s1_valid_q <= s0_valid_q;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv0 && in_valid_i) begin
      s0_q <= in_data_i;
    end
    if (move01) begin
      s1_q <= knob;
    end
    if (move12) begin
      s2_q <= result;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

endmodule

// ----- rtl/core/ecsc_regs.sv -----
// Configuration register file with APB-style access.
module ecsc_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [ecsc_pkg::AddrWidth-1:0]   paddr_i,
  input  logic [ecsc_pkg::DataWidth-1:0]   pwdata_i,
  output logic [ecsc_pkg::DataWidth-1:0]   prdata_o,
  output ecsc_pkg::cfg_t                   cfg_o,
  output ecsc_pkg::cfg_load_t              load_o
);

  ecsc_pkg::cfg_t       cfg_q;
  ecsc_pkg::reg_idx_e   idx;
  logic                 wr;

  assign wr  = psel_i & penable_i & pwrite_i;
  assign idx = ecsc_pkg::reg_idx_e'(paddr_i[ecsc_pkg::AddrWidth-1:2]);

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_setpoint <= ecsc_pkg::DefaultSetpointReset;
      cfg_q.step_size        <= ecsc_pkg::StepSizeReset;
      cfg_q.min_limit        <= ecsc_pkg::MinLimitReset;
      cfg_q.max_limit        <= ecsc_pkg::MaxLimitReset;
      cfg_q.initial_count    <= ecsc_pkg::InitialCountReset;
      cfg_q.debounce_ms      <= ecsc_pkg::DebounceMsReset;
      cfg_q.double_click_ms  <= ecsc_pkg::DoubleClickMsReset;
    end else if (wr) begin
      unique case (idx)
        ecsc_pkg::RegDefaultSetpoint: cfg_q.default_setpoint <= pwdata_i[15:0];
        ecsc_pkg::RegStepSize:        cfg_q.step_size        <= pwdata_i[14:0];
        ecsc_pkg::RegMinLimit:        cfg_q.min_limit        <= pwdata_i[15:0];
        ecsc_pkg::RegMaxLimit:        cfg_q.max_limit        <= pwdata_i[15:0];
        ecsc_pkg::RegInitialCount:    cfg_q.initial_count    <= pwdata_i[15:0];
        ecsc_pkg::RegDebounceMs:      cfg_q.debounce_ms      <= pwdata_i[15:0];
        ecsc_pkg::RegDoubleClickMs:   cfg_q.double_click_ms  <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Writes to the setpoint and count references also load live state
  assign load_o.setpoint_load = wr && (idx == ecsc_pkg::RegDefaultSetpoint);
  assign load_o.count_load    = wr && (idx == ecsc_pkg::RegInitialCount);
  assign load_o.value         = pwdata_i[15:0];

  // Readback, signed registers sign-extended
  always_comb begin
    unique case (idx)
      ecsc_pkg::RegDefaultSetpoint: prdata_o = 32'(cfg_q.default_setpoint);
      ecsc_pkg::RegStepSize:        prdata_o = {17'd0, cfg_q.step_size};
      ecsc_pkg::RegMinLimit:        prdata_o = 32'(cfg_q.min_limit);
      ecsc_pkg::RegMaxLimit:        prdata_o = 32'(cfg_q.max_limit);
      ecsc_pkg::RegInitialCount:    prdata_o = {16'd0, cfg_q.initial_count};
      ecsc_pkg::RegDebounceMs:      prdata_o = {16'd0, cfg_q.debounce_ms};
      ecsc_pkg::RegDoubleClickMs:   prdata_o = {16'd0, cfg_q.double_click_ms};
      default:                      prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/ecsc_input.sv -----
// Button debounce, click decision and encoder detent extraction stage.
module ecsc_input #(
  parameter int unsigned PulsesPerDetent = ecsc_pkg::PulsesPerDetentDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ecsc_pkg::in_item_t     item_i,
  input  ecsc_pkg::cfg_t         cfg_i,
  input  ecsc_pkg::cfg_load_t    load_i,
  output ecsc_pkg::knob_item_t   knob_o
);

  // Exact reciprocal for truncating division of a 16-bit magnitude
  localparam int unsigned DivShift  = 16 + $clog2(PulsesPerDetent);
  localparam int unsigned Recip     = (2**DivShift + PulsesPerDetent - 1) / PulsesPerDetent;
  localparam int unsigned ProdWidth = DivShift + 16;

  logic        held_q, held_d;
  logic [1:0]  tally_q, tally_d, tally_inc;
  logic [31:0] last_q, last_d;
  logic        edit_q, edit_d;
  logic        heat_q, heat_d;
  logic [15:0] consumed_q, consumed_d;

  logic        press_ok;
  logic        decide;
  logic [15:0] diff;
  logic        diff_neg;
  logic [15:0] mag;
  logic [ProdWidth-1:0] prod;
  logic [15:0] quot;
  logic [15:0] moved;

  // Press edge, counted only once the debounce time has passed
  assign press_ok  = item_i.button_pressed && !held_q &&
                     ((item_i.now_ms - last_q) > {16'd0, cfg_i.debounce_ms});
  assign held_d    = item_i.button_pressed & (held_q | press_ok);
  assign tally_inc = press_ok ? ((tally_q == 2'd3) ? 2'd3 : tally_q + 2'd1) : tally_q;
  assign last_d    = press_ok ? item_i.now_ms : last_q;

  // Click decision after the double-click window
  assign decide = (tally_inc != 2'd0) &&
                  ((item_i.now_ms - last_d) > {16'd0, cfg_i.double_click_ms});

  always_comb begin
    edit_d  = edit_q;
    heat_d  = heat_q;
    tally_d = tally_inc;
    if (decide) begin
      tally_d = 2'd0;
      if (tally_inc == 2'd1) begin
        edit_d = !edit_q;
      end else begin
        heat_d = !heat_q;
        if (heat_q) begin
          edit_d = 1'b0;
        end
      end
    end
  end

  // Whole detents from the wrapped counter difference, toward zero
  assign diff     = item_i.encoder_count - consumed_q;
  assign diff_neg = diff[15];
  assign mag      = diff_neg ? (16'd0 - diff) : diff;
  assign prod     = ProdWidth'(mag) * ProdWidth'(Recip);
  assign quot     = prod[ProdWidth-1:DivShift];
  assign moved    = 16'(quot * 16'(PulsesPerDetent));

  // Leftover pulses stay unconsumed
  assign consumed_d = diff_neg ? (consumed_q - moved) : (consumed_q + moved);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= 1'b0;
      tally_q    <= 2'd0;
      last_q     <= 32'd0;
      edit_q     <= 1'b1;
      heat_q     <= 1'b0;
      consumed_q <= ecsc_pkg::InitialCountReset;
    end else if (load_i.count_load) begin
      consumed_q <= load_i.value;
    end else if (en_i) begin
      held_q     <= held_d;
      tally_q    <= tally_d;
      last_q     <= last_d;
      edit_q     <= edit_d;
      heat_q     <= heat_d;
      consumed_q <= consumed_d;
    end
  end

  assign knob_o.steps           = diff_neg ? (16'd0 - quot) : quot;
  assign knob_o.edit_mode       = edit_d;
  assign knob_o.heating_enabled = heat_d;

endmodule

// ----- rtl/core/ecsc_setpoint.sv -----
// Setpoint step, clamp and state stage.
module ecsc_setpoint (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ecsc_pkg::knob_item_t   knob_i,
  input  ecsc_pkg::cfg_t         cfg_i,
  input  ecsc_pkg::cfg_load_t    load_i,
  output ecsc_pkg::out_item_t    result_o
);

  logic signed [15:0] setpoint_q, setpoint_d;
  logic signed [31:0] steps_ext, step_ext, delta;
  logic signed [32:0] sum, max_ext, min_ext, clamp_hi, clamp;

  // Detents times step size: at most 2^15 * (2^15-1), fits 32 bits
  assign steps_ext = 32'(knob_i.steps);
  assign step_ext  = 32'($signed({1'b0, cfg_i.step_size}));
  assign delta     = steps_ext * step_ext;

  // Add, then clamp to max and afterwards to min
  assign sum      = 33'(setpoint_q) + 33'(delta);
  assign max_ext  = 33'(cfg_i.max_limit);
  assign min_ext  = 33'(cfg_i.min_limit);
  assign clamp_hi = (sum > max_ext) ? max_ext : sum;
  assign clamp    = (clamp_hi < min_ext) ? min_ext : clamp_hi;

  assign setpoint_d = ((knob_i.steps != 16'sd0) && knob_i.edit_mode) ? 16'(clamp) : setpoint_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= ecsc_pkg::DefaultSetpointReset;
    end else if (load_i.setpoint_load) begin
      setpoint_q <= load_i.value;
    end else if (en_i) begin
      setpoint_q <= setpoint_d;
    end
  end

  assign result_o.setpoint        = setpoint_d;
  assign result_o.edit_mode       = knob_i.edit_mode;
  assign result_o.heating_enabled = knob_i.heating_enabled;

endmodule

// ----- rtl/core/ecsc_checker.sv -----
// Port-level checker for the setpoint control top level, with its bind.
module ecsc_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input ecsc_pkg::out_item_t   out_data_o
);

  // An empty result register never blocks the input side
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output side is empty");

  // With a free output, an accepted item reaches the output through the stage registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("accepted item did not reach the output in time");

  // A stalled result stays offered
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its value
  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("output item changed while stalled");

endmodule

bind encoder_click_setpoint_control ecsc_checker u_checker (.*);
